// ===== sv/vsb_pkg.sv =====
// ----------------------------------------------------------------------------
// vsb_pkg: shared types and constants of the vertex skinning blend core.
// Sizes of the bone palette, the datapath word widths and the codes of the
// opcode and status fields.
// ----------------------------------------------------------------------------
package vsb_pkg;

   // Number of bone matrices held in the palette.
   localparam int BONE_SLOTS = 256;
   localparam int BONE_AW    = (BONE_SLOTS > 1) ? $clog2(BONE_SLOTS) : 1;

   // Matrix and vector geometry.
   localparam int MAT_ELEMS = 16;
   localparam int VEC_LEN   = 4;
   localparam int WORD_W    = 32;
   localparam int WGT_W     = 17;

   // Divider: quotient bits, remainder bits and the bits retired per stage.
   localparam int QUO_W      = 32;
   localparam int REM_W      = WGT_W + 1;
   localparam int MAG_W      = QUO_W + REM_W;
   localparam int DIV_STEPS  = 4;
   localparam int DIV_STAGES = QUO_W / DIV_STEPS;

   // Register stages in front of the output queue.
   localparam int PIPE_STAGES = 5 + DIV_STAGES;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_SKIN = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_ZERO_WEIGHT = 2'd1,
      STATUS_SAT         = 2'd2
   } status_type;

   typedef logic [MAT_ELEMS-1:0][WORD_W-1:0] mat_type;
   typedef logic [VEC_LEN-1:0][WORD_W-1:0]   vec_type;

   // Side information that travels with a vertex down the pipeline.
   typedef struct packed {
      vec_type            pos;
      logic               pass;
      logic               use_b;
      logic [WGT_W-1:0]   wa;
      logic [WGT_W-1:0]   wb;
      logic               sat;
      logic               zero_w;
      logic [VEC_LEN-1:0] neg;
   } side_type;

   // One finished result beat.
   typedef struct packed {
      vec_type    coord;
      status_type status;
   } rsp_type;

endpackage

// ===== sv/vsb_req_if.sv =====
// ----------------------------------------------------------------------------
// vsb_req_if: request channel of the vertex skinning blend core.
// Carries a matrix load or a vertex to be skinned, with valid and ready.
// ----------------------------------------------------------------------------
interface vsb_req_if;
   logic               valid;
   logic               ready;
   logic               opcode;
   logic [7:0]         bone_a;
   logic [16:0]        weight_a;
   logic [7:0]         bone_b;
   logic [16:0]        weight_b;
   logic [1:0]         influence_count;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] pos_w;
   logic [3:0]         element_index;
   logic signed [31:0] element_value;

   modport source (
      output valid, opcode, bone_a, weight_a, bone_b, weight_b, influence_count,
      output pos_x, pos_y, pos_z, pos_w, element_index, element_value,
      input  ready
   );

   modport sink (
      input  valid, opcode, bone_a, weight_a, bone_b, weight_b, influence_count,
      input  pos_x, pos_y, pos_z, pos_w, element_index, element_value,
      output ready
   );
endinterface

// ===== sv/vsb_rsp_if.sv =====
// ----------------------------------------------------------------------------
// vsb_rsp_if: result channel of the vertex skinning blend core.
// Carries one skinned position and its status, with valid and ready.
// ----------------------------------------------------------------------------
interface vsb_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic signed [31:0] out_z;
   logic signed [31:0] out_w;
   logic [1:0]         status;

   modport source (
      output valid, out_x, out_y, out_z, out_w, status,
      input  ready
   );

   modport sink (
      input  valid, out_x, out_y, out_z, out_w, status,
      output ready
   );
endinterface

// ===== sv/vertex_skinning_blend_core.sv =====
// A vertex passes the palette read, transform, weighting, blend and divider stages;
// a load gives no result. Throughput: one beat per cycle, loads and vertices alike,
// while the output queue has room. Sixteen dual-read RAMs, one per matrix element.
// A two-entry output queue decouples the pipeline from the result channel.
// Synchronous reset clears the valid bits and the queue; the palette is not cleared.
// ----------------------------------------------------------------------------
// vertex_skinning_blend_core: linear blend skinning in fixed point.
// Palette RAMs, two bone transforms, weighting, normalising divider and an
// output queue; all but the queue advance on one pipeline enable.
// ----------------------------------------------------------------------------
module vertex_skinning_blend_core (
   input  logic       clock,
   input  logic       reset,
   vsb_req_if.sink    req_chan,
   vsb_rsp_if.source  rsp_chan
);

   localparam int LAST = vsb_pkg::PIPE_STAGES - 1;

   logic                        pipe_en;
   logic                        fire;
   logic                        skin_fire;
   logic                        load_we;
   logic [15:0]                 bone_a_ext;
   logic [15:0]                 bone_b_ext;
   logic                        rng_a;
   logic                        rng_b;
   logic [vsb_pkg::BONE_AW-1:0] addr_a;
   logic [vsb_pkg::BONE_AW-1:0] addr_b;
   vsb_pkg::mat_type            mat_a;
   vsb_pkg::mat_type            mat_b;

   logic [LAST:0]               valid_in;
   logic [LAST:0]               valid_ff;

   vsb_pkg::side_type           side1_in;
   vsb_pkg::side_type           side1_ff;
   vsb_pkg::side_type           side2_ff;
   vsb_pkg::side_type           side3_ff;
   vsb_pkg::side_type           side4_in;
   vsb_pkg::side_type           side4_ff;
   vsb_pkg::side_type           side5_in;
   vsb_pkg::side_type           side5_ff;
   vsb_pkg::side_type           divside_ff [vsb_pkg::DIV_STAGES];
   logic                        rng_a1_ff;
   logic                        rng_b1_ff;

   vsb_pkg::vec_type            row_a;
   vsb_pkg::vec_type            row_b;
   logic                        sat_a;
   logic                        sat_b;

   logic signed [49:0]          wprod_a_in [vsb_pkg::VEC_LEN];
   logic signed [49:0]          wprod_b_in [vsb_pkg::VEC_LEN];
   logic signed [49:0]          wprod_a_ff [vsb_pkg::VEC_LEN];
   logic signed [49:0]          wprod_b_ff [vsb_pkg::VEC_LEN];

   logic signed [50:0]          acc [vsb_pkg::VEC_LEN];
   logic [50:0]                 acc_abs [vsb_pkg::VEC_LEN];
   logic [vsb_pkg::MAG_W-1:0]   mag_in [vsb_pkg::VEC_LEN];
   logic [vsb_pkg::MAG_W-1:0]   mag_ff [vsb_pkg::VEC_LEN];
   logic [vsb_pkg::REM_W-1:0]   total_in;
   logic [vsb_pkg::REM_W-1:0]   total_ff;
   logic [vsb_pkg::QUO_W-1:0]   quo [vsb_pkg::VEC_LEN];

   vsb_pkg::rsp_type            result;
   vsb_pkg::rsp_type            head_in;
   vsb_pkg::rsp_type            head_ff;
   vsb_pkg::rsp_type            tail_in;
   vsb_pkg::rsp_type            tail_ff;
   logic [1:0]                  count_in;
   logic [1:0]                  count_ff;
   logic                        push;
   logic                        pop;

   // The pipeline advances whenever the output queue has room.
   assign pipe_en        = (count_ff != 2'd2);
   assign req_chan.ready = pipe_en;
   assign fire           = req_chan.valid && pipe_en;
   assign skin_fire      = fire && (req_chan.opcode == vsb_pkg::OP_SKIN);

   // Bone addresses and range checks.
   assign bone_a_ext = 16'(req_chan.bone_a);
   assign bone_b_ext = 16'(req_chan.bone_b);
   assign rng_a      = bone_a_ext < 16'(vsb_pkg::BONE_SLOTS);
   assign rng_b      = bone_b_ext < 16'(vsb_pkg::BONE_SLOTS);
   assign addr_a     = bone_a_ext[vsb_pkg::BONE_AW-1:0];
   assign addr_b     = bone_b_ext[vsb_pkg::BONE_AW-1:0];
   assign load_we    = fire && (req_chan.opcode == vsb_pkg::OP_LOAD) && rng_a;

   // One palette RAM per matrix element, read for both influences at once.
   for (genvar e = 0; e < vsb_pkg::MAT_ELEMS; e++) begin : g_pal
      vsb_ram #(
         .WIDTH (vsb_pkg::WORD_W),
         .DEPTH (vsb_pkg::BONE_SLOTS)
      ) u_ram (
         .clock   (clock),
         .we      (load_we && (req_chan.element_index == 4'(e))),
         .waddr   (addr_a),
         .wdata   (req_chan.element_value),
         .re      (pipe_en),
         .raddr_a (addr_a),
         .raddr_b (addr_b),
         .rdata_a (mat_a[e]),
         .rdata_b (mat_b[e])
      );
   end

   // Valid bits move with the data.
   assign valid_in = {valid_ff[LAST-1:0], skin_fire};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (pipe_en) begin
         valid_ff <= valid_in;
      end
   end

   // Side information captured at the input.
   always_comb begin
      side1_in        = '0;
      side1_in.pos[0] = req_chan.pos_x;
      side1_in.pos[1] = req_chan.pos_y;
      side1_in.pos[2] = req_chan.pos_z;
      side1_in.pos[3] = req_chan.pos_w;
      side1_in.pass   = (req_chan.influence_count == 2'd0);
      side1_in.use_b  = req_chan.influence_count[1];
      side1_in.wa     = req_chan.weight_a;
      side1_in.wb     = req_chan.weight_b;
   end

   // Bone transforms for both influences.
   vsb_xform u_xform_a (
      .clock    (clock),
      .en       (pipe_en),
      .mat      (mat_a),
      .in_range (rng_a1_ff),
      .vec      (side1_ff.pos),
      .row      (row_a),
      .sat      (sat_a)
   );

   vsb_xform u_xform_b (
      .clock    (clock),
      .en       (pipe_en),
      .mat      (mat_b),
      .in_range (rng_b1_ff),
      .vec      (side1_ff.pos),
      .row      (row_b),
      .sat      (sat_b)
   );

   // Weighting of each transformed row.
   always_comb begin
      side4_in     = side3_ff;
      side4_in.sat = sat_a || (side3_ff.use_b && sat_b);
      for (int r = 0; r < vsb_pkg::VEC_LEN; r++) begin
         wprod_a_in[r] = $signed(row_a[r]) * $signed({1'b0, side3_ff.wa});
         wprod_b_in[r] = $signed(row_b[r]) * $signed({1'b0, side3_ff.wb});
      end
   end

   // Blend sum, total weight and sign-magnitude split for the divider.
   always_comb begin
      side5_in = side4_ff;
      total_in = vsb_pkg::REM_W'(side4_ff.wa)
               + (side4_ff.use_b ? vsb_pkg::REM_W'(side4_ff.wb) : '0);
      side5_in.zero_w = (total_in == '0);
      for (int r = 0; r < vsb_pkg::VEC_LEN; r++) begin
         acc[r] = 51'(wprod_a_ff[r]) + (side4_ff.use_b ? 51'(wprod_b_ff[r]) : 51'sd0);
         side5_in.neg[r] = acc[r][50];
         acc_abs[r]      = acc[r][50] ? 51'(-acc[r]) : 51'(acc[r]);
         mag_in[r]       = acc_abs[r][vsb_pkg::MAG_W-1:0];
      end
   end

   // Payload registers of the input, transform, weighting and blend stages.
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         side1_ff   <= side1_in;
         rng_a1_ff  <= rng_a;
         rng_b1_ff  <= rng_b;
         side2_ff   <= side1_ff;
         side3_ff   <= side2_ff;
         side4_ff   <= side4_in;
         wprod_a_ff <= wprod_a_in;
         wprod_b_ff <= wprod_b_in;
         side5_ff   <= side5_in;
         mag_ff     <= mag_in;
         total_ff   <= total_in;
      end
   end

   // Normalising dividers, one per coordinate.
   for (genvar r = 0; r < vsb_pkg::VEC_LEN; r++) begin : g_div
      vsb_divider u_div (
         .clock    (clock),
         .en       (pipe_en),
         .dividend (mag_ff[r]),
         .divisor  (total_ff),
         .quotient (quo[r])
      );
   end

   // Side information alongside the divider stages.
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         divside_ff[0] <= side5_ff;
         for (int s = 1; s < vsb_pkg::DIV_STAGES; s++) begin
            divside_ff[s] <= divside_ff[s - 1];
         end
      end
   end

   // Sign restore and selection of the special cases.
   always_comb begin
      result = '0;
      if (divside_ff[vsb_pkg::DIV_STAGES-1].pass) begin
         result.coord  = divside_ff[vsb_pkg::DIV_STAGES-1].pos;
         result.status = vsb_pkg::STATUS_OK;
      end else if (divside_ff[vsb_pkg::DIV_STAGES-1].zero_w) begin
         result.coord  = '0;
         result.status = vsb_pkg::STATUS_ZERO_WEIGHT;
      end else begin
         for (int r = 0; r < vsb_pkg::VEC_LEN; r++) begin
            result.coord[r] = divside_ff[vsb_pkg::DIV_STAGES-1].neg[r] ? -quo[r] : quo[r];
         end
         result.status = divside_ff[vsb_pkg::DIV_STAGES-1].sat ? vsb_pkg::STATUS_SAT
                                                             : vsb_pkg::STATUS_OK;
      end
   end

   // Two-entry output queue.
   assign push = pipe_en && valid_ff[LAST];
   assign pop  = rsp_chan.valid && rsp_chan.ready;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
      unique case (count_ff)
         2'd0: begin
            if (push) begin
               head_in = result;
            end
         end
         2'd1: begin
            if (push && pop) begin
               head_in = result;
            end else if (push) begin
               tail_in = result;
            end
         end
         2'd2: begin
            if (pop) begin
               head_in = tail_ff;
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign rsp_chan.valid  = (count_ff != 2'd0);
   assign rsp_chan.out_x  = head_ff.coord[0];
   assign rsp_chan.out_y  = head_ff.coord[1];
   assign rsp_chan.out_z  = head_ff.coord[2];
   assign rsp_chan.out_w  = head_ff.coord[3];
   assign rsp_chan.status = head_ff.status;

   // A matrix load never starts a result.
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (fire && (req_chan.opcode == vsb_pkg::OP_LOAD)) |=> !valid_ff[0])
      else $error("matrix load entered the pipeline as a vertex");

   // The queue never holds more than two beats.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("output queue overfilled");

   // A stalled pipeline keeps every valid bit in place.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (!reset && !pipe_en) |=> $stable(valid_ff))
      else $error("pipeline moved while stalled");

   // A zero total weight yields a zero position.
   a_zero_weight: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status == vsb_pkg::STATUS_ZERO_WEIGHT)) |->
      ((rsp_chan.out_x == 32'sd0) && (rsp_chan.out_y == 32'sd0) &&
       (rsp_chan.out_z == 32'sd0) && (rsp_chan.out_w == 32'sd0)))
      else $error("zero weight result with non-zero position");

endmodule

// ===== sv/vsb_ram.sv =====
// ----------------------------------------------------------------------------
// vsb_ram: generic RAM with one write port and two registered read ports.
// The read data registers load only while the read enable is high.
// ----------------------------------------------------------------------------
module vsb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic                                     re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
   output logic [WIDTH-1:0]                         rdata_a,
   output logic [WIDTH-1:0]                         rdata_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   // Write port and registered reads.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_a_ff <= mem[raddr_a];
         rdata_b_ff <= mem[raddr_b];
      end
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

// ===== sv/vsb_xform.sv =====
// ----------------------------------------------------------------------------
// vsb_xform: matrix times vector for one bone, in two register stages.
// Stage one forms the sixteen products floored to Q32.16, stage two sums
// each row and saturates it to Q16.16.
// ----------------------------------------------------------------------------
module vsb_xform (
   input  logic              clock,
   input  logic              en,
   input  vsb_pkg::mat_type  mat,
   input  logic              in_range,
   input  vsb_pkg::vec_type  vec,
   output vsb_pkg::vec_type  row,
   output logic              sat
);

   localparam logic signed [49:0] SAT_MAX = 50'sd2147483647;
   localparam logic signed [49:0] SAT_MIN = -50'sd2147483648;

   logic signed [63:0] full   [vsb_pkg::MAT_ELEMS];
   logic signed [47:0] prod_in [vsb_pkg::MAT_ELEMS];
   logic signed [47:0] prod_ff [vsb_pkg::MAT_ELEMS];
   logic signed [49:0] sum    [vsb_pkg::VEC_LEN];
   vsb_pkg::vec_type   row_in;
   vsb_pkg::vec_type   row_ff;
   logic               sat_in;
   logic               sat_ff;

   // Products; an arithmetic shift by 16 rounds toward minus infinity.
   always_comb begin
      for (int e = 0; e < vsb_pkg::MAT_ELEMS; e++) begin
         full[e]    = $signed(in_range ? mat[e] : 32'd0) * $signed(vec[e >> 2]);
         prod_in[e] = full[e][63:16];
      end
   end

   // Row sums with saturation.
   always_comb begin
      sat_in = 1'b0;
      for (int r = 0; r < vsb_pkg::VEC_LEN; r++) begin
         sum[r] = 50'(prod_ff[r]) + 50'(prod_ff[4 + r]) + 50'(prod_ff[8 + r])
                + 50'(prod_ff[12 + r]);
         if (sum[r] > SAT_MAX) begin
            row_in[r] = 32'h7FFF_FFFF;
            sat_in    = 1'b1;
         end else if (sum[r] < SAT_MIN) begin
            row_in[r] = 32'h8000_0000;
            sat_in    = 1'b1;
         end else begin
            row_in[r] = sum[r][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         row_ff  <= row_in;
         sat_ff  <= sat_in;
      end
   end

   assign row = row_ff;
   assign sat = sat_ff;

endmodule

// ===== sv/vsb_divider.sv =====
// ----------------------------------------------------------------------------
// vsb_divider: pipelined restoring divider for the weight normalisation.
// Each stage retires four quotient bits; the quotient shifts into the low
// dividend bits as they are consumed.
// ----------------------------------------------------------------------------
module vsb_divider (
   input  logic                        clock,
   input  logic                        en,
   input  logic [vsb_pkg::MAG_W-1:0]   dividend,
   input  logic [vsb_pkg::REM_W-1:0]   divisor,
   output logic [vsb_pkg::QUO_W-1:0]   quotient
);

   logic [vsb_pkg::REM_W-1:0] rem_in [vsb_pkg::DIV_STAGES];
   logic [vsb_pkg::REM_W-1:0] rem_ff [vsb_pkg::DIV_STAGES];
   logic [vsb_pkg::REM_W-1:0] dvs_in [vsb_pkg::DIV_STAGES];
   logic [vsb_pkg::REM_W-1:0] dvs_ff [vsb_pkg::DIV_STAGES];
   logic [vsb_pkg::QUO_W-1:0] low_in [vsb_pkg::DIV_STAGES];
   logic [vsb_pkg::QUO_W-1:0] low_ff [vsb_pkg::DIV_STAGES];

   // Compare and subtract steps of every stage.
   always_comb begin
      logic [vsb_pkg::REM_W:0]   trial;
      logic [vsb_pkg::REM_W-1:0] r;
      logic [vsb_pkg::REM_W-1:0] d;
      logic [vsb_pkg::QUO_W-1:0] q;
      for (int s = 0; s < vsb_pkg::DIV_STAGES; s++) begin
         if (s == 0) begin
            r = dividend[vsb_pkg::MAG_W-1:vsb_pkg::QUO_W];
            q = dividend[vsb_pkg::QUO_W-1:0];
            d = divisor;
         end else begin
            r = rem_ff[s - 1];
            q = low_ff[s - 1];
            d = dvs_ff[s - 1];
         end
         for (int k = 0; k < vsb_pkg::DIV_STEPS; k++) begin
            trial = {r, q[vsb_pkg::QUO_W-1]};
            q     = {q[vsb_pkg::QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, d}) begin
               trial = trial - {1'b0, d};
               q[0]  = 1'b1;
            end
            r = trial[vsb_pkg::REM_W-1:0];
         end
         rem_in[s] = r;
         low_in[s] = q;
         dvs_in[s] = d;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         low_ff <= low_in;
         dvs_ff <= dvs_in;
      end
   end

   assign quotient = low_ff[vsb_pkg::DIV_STAGES-1];

endmodule
